// ----- rtl/cobf_pkg.sv -----
// Package for the channel object bring-up sequencer.
// Holds the object state enum, event and availability codes, and the
// request and result payload types; it depends on nothing else.
`timescale 1ns / 1ps

package cobf_pkg;

  typedef enum logic [1:0] {
    ST_NOT_INSTALLED = 2'd0,
    ST_DEPENDENCY    = 2'd1,
    ST_OFFLINE       = 2'd2,
    ST_ENABLED       = 2'd3
  } state_t;

  localparam logic [2:0] OP_SW_ACT_REPORT  = 3'd0;
  localparam logic [2:0] OP_STATE_CHANGE   = 3'd1;
  localparam logic [2:0] OP_SET_ATTR_ACK   = 3'd2;
  localparam logic [2:0] OP_OPSTART_ACK    = 3'd3;
  localparam logic [2:0] OP_OPSTART_NACK   = 3'd4;
  localparam logic [2:0] OP_LINK_DOWN      = 3'd5;

  localparam logic [2:0] AV_NOT_INSTALLED  = 3'd0;
  localparam logic [2:0] AV_POWER_OFF      = 3'd1;
  localparam logic [2:0] AV_DEPENDENCY     = 3'd2;
  localparam logic [2:0] AV_OFF_LINE       = 3'd3;
  localparam logic [2:0] AV_OK             = 3'd4;

  typedef struct packed {
    logic [2:0] operation;
    logic       reported_operational;
    logic [2:0] reported_availability;
    logic       reported_admin_unlocked;
    logic       stored_admin_unlocked;
  } req_t;

  typedef struct packed {
    logic [1:0] object_state;
    logic       send_set_attributes;
    logic       send_admin_unlock;
    logic       send_opstart;
    logic       event_rejected;
  } rsp_t;

endpackage

// ----- rtl/cobf_if.sv -----
// Valid/ready channel interfaces for the bring-up sequencer.
// Uses the request and result types of cobf_pkg.
`timescale 1ns / 1ps

interface cobf_req_if;
  logic             valid;
  logic             ready;
  cobf_pkg::req_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cobf_rsp_if;
  logic             valid;
  logic             ready;
  cobf_pkg::rsp_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cobf_cfg_if;
  logic valid;
  logic ready;
  logic peer_lacks_offline;
  modport source (output valid, output peer_lacks_offline, input ready);
  modport sink   (input valid, input peer_lacks_offline, output ready);
endinterface

// ----- rtl/channel_object_bringup_fsm_core.sv -----
// Top level of the channel object bring-up sequencer.
// Depends on cobf_pkg and the channel interfaces in cobf_if.sv.
//
// A request is held in the input register, and its result in the result register.
// Throughput is one request per cycle unless out_if.ready stalls the result;
// the state decision between the input register and the result register sets that figure.
// Reset clears the object state, the four handshake flags and the config bit.
`timescale 1ns / 1ps

module channel_object_bringup_fsm_core (
  input  logic       clk,
  input  logic       rst_n,
  cobf_req_if.sink   in_if,
  cobf_rsp_if.source out_if,
  cobf_cfg_if.sink   cfg_if
);
  import cobf_pkg::*;

  logic   in_vld_r;
  req_t   in_data_r;
  logic   out_vld_r;
  rsp_t   out_data_r;
  logic   adv;

  state_t state_r, state_nxt;
  logic   attr_pend_r, attr_pend_nxt;
  logic   attr_ack_r, attr_ack_nxt;
  logic   unlock_req_r, unlock_req_nxt;
  logic   opstart_pend_r, opstart_pend_nxt;
  logic   plo_r;

  logic   enter;
  state_t tgt;
  logic   pass_run, pass_admin, pass_allow;
  logic   ack_evt, clr_opstart, rejected;
  logic   req_set, req_unlock, req_opstart;
  logic   fl_pend, fl_ack, fl_unlock, fl_op;

  assign adv          = in_vld_r && (!out_vld_r || out_if.ready);
  assign in_if.ready  = !in_vld_r || adv;
  assign out_if.valid = out_vld_r;
  assign out_if.data  = out_data_r;
  assign cfg_if.ready = 1'b1;

  // Event decode: which state is entered and which configure pass runs.
  always_comb begin
    enter       = 1'b0;
    tgt         = state_r;
    pass_run    = 1'b0;
    pass_admin  = in_data_r.reported_admin_unlocked;
    pass_allow  = 1'b0;
    ack_evt     = 1'b0;
    clr_opstart = 1'b0;
    rejected    = 1'b0;
    unique case (in_data_r.operation)
      OP_SW_ACT_REPORT: rejected = (state_r != ST_NOT_INSTALLED);
      OP_STATE_CHANGE: begin
        if (in_data_r.reported_operational) begin
          enter = (state_r != ST_ENABLED);
          tgt   = ST_ENABLED;
        end else if (in_data_r.reported_availability == AV_NOT_INSTALLED ||
                     in_data_r.reported_availability == AV_POWER_OFF) begin
          enter = (state_r != ST_NOT_INSTALLED);
          tgt   = ST_NOT_INSTALLED;
        end else if (in_data_r.reported_availability == AV_DEPENDENCY) begin
          if (state_r == ST_DEPENDENCY) begin
            pass_run = 1'b1;
          end else if (state_r == ST_OFFLINE && plo_r) begin
            pass_run   = 1'b1;
            pass_allow = 1'b1;
          end else begin
            enter = 1'b1;
            tgt   = ST_DEPENDENCY;
          end
        end else if (in_data_r.reported_availability == AV_OFF_LINE ||
                     in_data_r.reported_availability == AV_OK) begin
          if (state_r == ST_OFFLINE) begin
            pass_run   = 1'b1;
            pass_allow = 1'b1;
          end else begin
            enter = 1'b1;
            tgt   = ST_OFFLINE;
          end
        end
      end
      OP_SET_ATTR_ACK: begin
        if (state_r == ST_DEPENDENCY || state_r == ST_OFFLINE) begin
          ack_evt    = 1'b1;
          pass_run   = 1'b1;
          pass_admin = in_data_r.stored_admin_unlocked;
          pass_allow = (state_r == ST_OFFLINE);
        end else begin
          rejected = 1'b1;
        end
      end
      OP_OPSTART_ACK, OP_OPSTART_NACK: clr_opstart = 1'b1;
      OP_LINK_DOWN: begin
        enter = (state_r != ST_NOT_INSTALLED);
        tgt   = ST_NOT_INSTALLED;
      end
      default: rejected = 1'b1;
    endcase
    if (enter) begin
      if (tgt == ST_DEPENDENCY && plo_r) begin
        tgt = ST_OFFLINE;
      end
      pass_admin = in_data_r.stored_admin_unlocked;
      pass_run   = (tgt == ST_DEPENDENCY || tgt == ST_OFFLINE);
      pass_allow = (tgt == ST_OFFLINE);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    if (adv && enter) begin
      state_nxt = tgt;
    end
  end

  // Flags and requests.
  always_comb begin
    fl_pend     = attr_pend_r;
    fl_ack      = attr_ack_r;
    fl_unlock   = unlock_req_r;
    fl_op       = opstart_pend_r;
    req_set     = 1'b0;
    req_unlock  = 1'b0;
    req_opstart = 1'b0;
    if (ack_evt) begin
      fl_ack  = 1'b1;
      fl_pend = 1'b0;
    end
    if (clr_opstart) begin
      fl_op = 1'b0;
    end
    if (enter && (tgt == ST_NOT_INSTALLED || tgt == ST_ENABLED)) begin
      fl_pend   = 1'b0;
      fl_ack    = 1'b0;
      fl_unlock = 1'b0;
      fl_op     = 1'b0;
    end
    if (pass_run) begin
      if (!fl_pend && !fl_ack) begin
        fl_pend = 1'b1;
        req_set = 1'b1;
      end
      if (!pass_admin && !fl_unlock) begin
        fl_unlock  = 1'b1;
        req_unlock = 1'b1;
      end
      if (pass_allow && pass_admin && fl_ack && !fl_op) begin
        fl_op       = 1'b1;
        req_opstart = 1'b1;
      end
    end
    attr_pend_nxt    = adv ? fl_pend   : attr_pend_r;
    attr_ack_nxt     = adv ? fl_ack    : attr_ack_r;
    unlock_req_nxt   = adv ? fl_unlock : unlock_req_r;
    opstart_pend_nxt = adv ? fl_op     : opstart_pend_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r       <= 1'b0;
      out_vld_r      <= 1'b0;
      state_r        <= ST_NOT_INSTALLED;
      attr_pend_r    <= 1'b0;
      attr_ack_r     <= 1'b0;
      unlock_req_r   <= 1'b0;
      opstart_pend_r <= 1'b0;
      plo_r          <= 1'b0;
    end else begin
      if (in_if.ready) begin
        in_vld_r <= in_if.valid;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_r <= 1'b0;
      end
      state_r        <= state_nxt;
      attr_pend_r    <= attr_pend_nxt;
      attr_ack_r     <= attr_ack_nxt;
      unlock_req_r   <= unlock_req_nxt;
      opstart_pend_r <= opstart_pend_nxt;
      if (cfg_if.valid) begin
        plo_r <= cfg_if.peer_lacks_offline;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_data_r <= in_if.data;
    end
    if (adv) begin
      out_data_r.object_state        <= state_nxt;
      out_data_r.send_set_attributes <= req_set;
      out_data_r.send_admin_unlock   <= req_unlock;
      out_data_r.send_opstart        <= req_opstart;
      out_data_r.event_rejected      <= rejected;
    end
  end

  a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_data_r.event_rejected |->
      !out_data_r.send_set_attributes && !out_data_r.send_admin_unlock &&
      !out_data_r.send_opstart)
    else $error("rejected event carries a request");

  a_opstart_offline: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_data_r.send_opstart |->
      out_data_r.object_state == ST_OFFLINE)
    else $error("opstart requested outside the offline state");

  a_flags_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_NOT_INSTALLED || state_r == ST_ENABLED |->
      !attr_pend_r && !attr_ack_r && !unlock_req_r && !opstart_pend_r)
    else $error("handshake flags set in not installed or enabled");

  a_attr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(attr_pend_r && attr_ack_r))
    else $error("attribute request both pending and acknowledged");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(state_r))
    else $error("state changed without an accepted request");

endmodule

// ----- tb/cobf_bringup_checker.sv -----
// Checker for the channel object bring-up sequencer: predicts each result from
// the accepted requests and register writes, and compares the results in order.
// Depends on cobf_pkg for the request, result and state types.
`timescale 1ns / 1ps

module cobf_bringup_checker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  cobf_pkg::req_t   in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  cobf_pkg::rsp_t   out_data,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic             cfg_peer_lacks_offline,
  output int               mismatch_count,
  output int               pending_results
);
  import cobf_pkg::*;

  state_t obj_state;
  logic   attr_pending;
  logic   attr_acked;
  logic   unlock_sent;
  logic   opstart_wait;
  logic   peer_no_offline;
  logic   want_set;
  logic   want_unlock;
  logic   want_opstart;

  rsp_t   expected_results[$];
  rsp_t   next_expected;
  rsp_t   predicted;
  int     mismatch_total;

  task automatic apply_configure(input logic admin, input logic allow);
    if (!attr_pending && !attr_acked) begin
      attr_pending = 1'b1;
      want_set = 1'b1;
    end
    if (!admin && !unlock_sent) begin
      unlock_sent = 1'b1;
      want_unlock = 1'b1;
    end
    if (allow && admin && attr_acked && !opstart_wait) begin
      opstart_wait = 1'b1;
      want_opstart = 1'b1;
    end
  endtask

  task automatic clear_handshakes();
    attr_pending = 1'b0;
    attr_acked = 1'b0;
    unlock_sent = 1'b0;
    opstart_wait = 1'b0;
  endtask

  task automatic move_to(input state_t target, input logic stored_admin);
    state_t dest;
    dest = target;
    if (dest == ST_DEPENDENCY && peer_no_offline) dest = ST_OFFLINE;
    obj_state = dest;
    case (dest)
      ST_NOT_INSTALLED, ST_ENABLED: clear_handshakes();
      ST_DEPENDENCY: apply_configure(stored_admin, 1'b0);
      default: apply_configure(stored_admin, 1'b1);
    endcase
  endtask

  task automatic predict_bringup(input req_t ev, output rsp_t res);
    state_t cur;
    logic   rejected;
    cur = obj_state;
    rejected = 1'b0;
    want_set = 1'b0;
    want_unlock = 1'b0;
    want_opstart = 1'b0;
    case (ev.operation)
      OP_SW_ACT_REPORT: begin
        if (cur != ST_NOT_INSTALLED) rejected = 1'b1;
      end
      OP_STATE_CHANGE: begin
        if (ev.reported_operational) begin
          if (cur != ST_ENABLED) move_to(ST_ENABLED, ev.stored_admin_unlocked);
        end else if (ev.reported_availability == AV_NOT_INSTALLED ||
                     ev.reported_availability == AV_POWER_OFF) begin
          if (cur != ST_NOT_INSTALLED) move_to(ST_NOT_INSTALLED, ev.stored_admin_unlocked);
        end else if (ev.reported_availability == AV_DEPENDENCY) begin
          if (cur == ST_DEPENDENCY) begin
            apply_configure(ev.reported_admin_unlocked, 1'b0);
          end else if (cur == ST_OFFLINE && peer_no_offline) begin
            apply_configure(ev.reported_admin_unlocked, 1'b1);
          end else begin
            move_to(ST_DEPENDENCY, ev.stored_admin_unlocked);
          end
        end else if (ev.reported_availability == AV_OFF_LINE ||
                     ev.reported_availability == AV_OK) begin
          if (cur == ST_OFFLINE) begin
            apply_configure(ev.reported_admin_unlocked, 1'b1);
          end else begin
            move_to(ST_OFFLINE, ev.stored_admin_unlocked);
          end
        end
      end
      OP_SET_ATTR_ACK: begin
        if (cur == ST_DEPENDENCY || cur == ST_OFFLINE) begin
          attr_acked = 1'b1;
          attr_pending = 1'b0;
          apply_configure(ev.stored_admin_unlocked, cur == ST_OFFLINE);
        end else begin
          rejected = 1'b1;
        end
      end
      OP_OPSTART_ACK, OP_OPSTART_NACK: begin
        opstart_wait = 1'b0;
      end
      OP_LINK_DOWN: begin
        if (cur != ST_NOT_INSTALLED) move_to(ST_NOT_INSTALLED, ev.stored_admin_unlocked);
      end
      default: begin
        rejected = 1'b1;
      end
    endcase
    res.object_state = obj_state;
    res.send_set_attributes = want_set;
    res.send_admin_unlock = want_unlock;
    res.send_opstart = want_opstart;
    res.event_rejected = rejected;
  endtask

  task automatic check_field(input string field, input int expv, input int actv);
    if (expv != actv) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, expv, actv);
      mismatch_total++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      obj_state = ST_NOT_INSTALLED;
      clear_handshakes();
      peer_no_offline = 1'b0;
      expected_results.delete();
      mismatch_total = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: result with no request outstanding, expected none, actual %h",
                   $time, out_data);
          mismatch_total++;
        end else begin
          next_expected = expected_results.pop_front();
          check_field("object_state", next_expected.object_state, out_data.object_state);
          check_field("send_set_attributes", next_expected.send_set_attributes,
                      out_data.send_set_attributes);
          check_field("send_admin_unlock", next_expected.send_admin_unlock,
                      out_data.send_admin_unlock);
          check_field("send_opstart", next_expected.send_opstart, out_data.send_opstart);
          check_field("event_rejected", next_expected.event_rejected,
                      out_data.event_rejected);
        end
      end
      if (cfg_valid && cfg_ready) peer_no_offline = cfg_peer_lacks_offline;
      if (in_valid && in_ready) begin
        predict_bringup(in_data, predicted);
        expected_results.push_back(predicted);
      end
    end
    mismatch_count <= mismatch_total;
    pending_results <= expected_results.size();
  end

endmodule

// ----- tb/channel_object_bringup_fsm_core_tb.sv -----
// Top of the bring-up sequencer testbench: drives requests, register writes and
// result backpressure, and reports the verdict from cobf_bringup_checker.
// Depends on cobf_pkg, the channel interfaces and channel_object_bringup_fsm_core.
`timescale 1ns / 1ps

module channel_object_bringup_fsm_core_tb;
  import cobf_pkg::*;

  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;
  localparam logic [2:0] AV_OTHER = 3'd5;
  localparam logic [2:0] AV_CODE_7 = 3'd7;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 185;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cobf_req_if in_ch();
  cobf_rsp_if out_ch();
  cobf_cfg_if cfg_ch();

  int mismatches;
  int pending;
  int sent_items = 0;
  int stall_cycles = 0;
  int hold_len = 0;
  bit idle_on = 1'b1;

  channel_object_bringup_fsm_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  cobf_bringup_checker checker_inst (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_ch.valid),
    .in_ready               (in_ch.ready),
    .in_data                (in_ch.data),
    .out_valid              (out_ch.valid),
    .out_ready              (out_ch.ready),
    .out_data               (out_ch.data),
    .cfg_valid              (cfg_ch.valid),
    .cfg_ready              (cfg_ch.ready),
    .cfg_peer_lacks_offline (cfg_ch.peer_lacks_offline),
    .mismatch_count         (mismatches),
    .pending_results        (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("** channel_object_bringup_fsm_core: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int n;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic bit coin();
    return bit'($urandom_range(0, 1));
  endfunction

  function automatic req_t make_event(input logic [2:0] op, input logic oper,
                                      input logic [2:0] avail, input logic rep,
                                      input logic sto);
    req_t ev;
    ev.operation = op;
    ev.reported_operational = oper;
    ev.reported_availability = avail;
    ev.reported_admin_unlocked = rep;
    ev.stored_admin_unlocked = sto;
    return ev;
  endfunction

  function automatic req_t random_event();
    return make_event(3'($urandom_range(0, 7)), coin(), 3'($urandom_range(0, 7)),
                      coin(), coin());
  endfunction

  task automatic send_event(input req_t ev);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= ev;
    do @(posedge clk); while (!in_ch.ready);
    sent_items++;
  endtask

  task automatic send_step(input req_t ev);
    if ($urandom_range(0, 9) == 0) send_event(random_event());
    else send_event(ev);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_peer_mode(input logic lacks_offline);
    cfg_ch.valid <= 1'b1;
    cfg_ch.peer_lacks_offline <= lacks_offline;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_bringup();
    logic [2:0] up_avail;
    up_avail = coin() ? AV_OFF_LINE : AV_OK;
    if ($urandom_range(0, 2) == 0) begin
      send_step(make_event(OP_LINK_DOWN, coin(), 3'($urandom_range(0, 7)), coin(), coin()));
    end
    send_step(make_event(OP_SW_ACT_REPORT, coin(), 3'($urandom_range(0, 7)), coin(), coin()));
    if (coin()) begin
      send_step(make_event(OP_STATE_CHANGE, 1'b0, AV_DEPENDENCY, coin(), coin()));
      if (coin()) send_step(make_event(OP_SET_ATTR_ACK, coin(), AV_DEPENDENCY, coin(), coin()));
      if (coin()) send_step(make_event(OP_STATE_CHANGE, 1'b0, AV_DEPENDENCY, coin(), coin()));
    end
    send_step(make_event(OP_STATE_CHANGE, 1'b0, up_avail, coin(), coin()));
    send_step(make_event(OP_SET_ATTR_ACK, coin(), up_avail, coin(),
                         $urandom_range(0, 3) != 0));
    if (coin()) send_step(make_event(OP_STATE_CHANGE, 1'b0, up_avail, 1'b1, coin()));
    send_step(make_event(coin() ? OP_OPSTART_ACK : OP_OPSTART_NACK, coin(), up_avail,
                         coin(), coin()));
    if (coin()) send_step(make_event(OP_STATE_CHANGE, 1'b0, up_avail, coin(), coin()));
    case ($urandom_range(0, 5))
      0, 1, 2: send_step(make_event(OP_STATE_CHANGE, 1'b1, 3'($urandom_range(0, 7)),
                                    coin(), coin()));
      3: send_step(make_event(OP_STATE_CHANGE, 1'b0, coin() ? AV_POWER_OFF : AV_NOT_INSTALLED,
                              coin(), coin()));
      4: send_step(make_event(OP_LINK_DOWN, coin(), up_avail, coin(), coin()));
      default: send_step(make_event(OP_STATE_CHANGE, 1'b0, AV_DEPENDENCY, coin(), coin()));
    endcase
  endtask

  initial begin
    int phase_start;
    bit paused;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.peer_lacks_offline = 1'b0;
    paused = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    write_peer_mode(1'b0);
    send_event(make_event(OP_UNUSED_6, 1'b1, AV_CODE_7, 1'b1, 1'b1));
    send_event(make_event(OP_UNUSED_7, 1'b0, AV_NOT_INSTALLED, 1'b0, 1'b0));
    send_event(make_event(OP_SET_ATTR_ACK, 1'b0, AV_NOT_INSTALLED, 1'b0, 1'b1));
    send_event(make_event(OP_SW_ACT_REPORT, 1'b0, AV_NOT_INSTALLED, 1'b0, 1'b0));
    send_event(make_event(OP_STATE_CHANGE, 1'b0, AV_DEPENDENCY, 1'b0, 1'b0));
    send_event(make_event(OP_SET_ATTR_ACK, 1'b0, AV_DEPENDENCY, 1'b0, 1'b1));
    send_event(make_event(OP_STATE_CHANGE, 1'b0, AV_OFF_LINE, 1'b0, 1'b1));
    send_event(make_event(OP_OPSTART_NACK, 1'b0, AV_OFF_LINE, 1'b0, 1'b1));
    send_event(make_event(OP_STATE_CHANGE, 1'b0, AV_OK, 1'b1, 1'b0));
    send_event(make_event(OP_OPSTART_ACK, 1'b0, AV_OK, 1'b1, 1'b1));
    send_event(make_event(OP_STATE_CHANGE, 1'b0, AV_OTHER, 1'b1, 1'b1));
    send_event(make_event(OP_STATE_CHANGE, 1'b0, AV_CODE_7, 1'b0, 1'b0));
    send_event(make_event(OP_STATE_CHANGE, 1'b1, AV_CODE_7, 1'b1, 1'b1));
    send_event(make_event(OP_SW_ACT_REPORT, 1'b1, AV_OK, 1'b1, 1'b1));
    send_event(make_event(OP_SET_ATTR_ACK, 1'b1, AV_OK, 1'b1, 1'b1));
    send_event(make_event(OP_STATE_CHANGE, 1'b1, AV_OK, 1'b0, 1'b0));
    send_event(make_event(OP_STATE_CHANGE, 1'b0, AV_POWER_OFF, 1'b0, 1'b0));
    send_event(make_event(OP_LINK_DOWN, 1'b0, AV_NOT_INSTALLED, 1'b0, 1'b0));
    send_event(make_event(OP_STATE_CHANGE, 1'b0, AV_OFF_LINE, 1'b0, 1'b0));
    send_event(make_event(OP_LINK_DOWN, 1'b1, AV_OFF_LINE, 1'b1, 1'b1));
    drain_results();
    write_peer_mode(1'b1);
    send_event(make_event(OP_STATE_CHANGE, 1'b0, AV_DEPENDENCY, 1'b0, 1'b1));
    send_event(make_event(OP_SET_ATTR_ACK, 1'b0, AV_DEPENDENCY, 1'b0, 1'b1));
    send_event(make_event(OP_STATE_CHANGE, 1'b0, AV_DEPENDENCY, 1'b0, 1'b1));
    send_event(make_event(OP_STATE_CHANGE, 1'b0, AV_NOT_INSTALLED, 1'b1, 1'b0));

    for (int phase = 0; phase < 6; phase++) begin
      drain_results();
      write_peer_mode(phase == 3 ? coin() : (phase % 2 == 0));
      idle_on = !(phase == 1 || phase == 5);
      phase_start = sent_items;
      if (phase == 2) begin
        hold_len = 60;
        idle_on = 1'b0;
        repeat (6) run_bringup();
        idle_on = 1'b1;
      end
      while (sent_items - phase_start < PHASE_ITEMS) begin
        if (phase == 3 && !paused && sent_items - phase_start >= PHASE_ITEMS / 2) begin
          drain_results();
          paused = 1'b1;
        end
        if ($urandom_range(0, 9) < 7) begin
          run_bringup();
        end else begin
          repeat ($urandom_range(1, 4)) send_event(random_event());
        end
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("** channel_object_bringup_fsm_core: PASSED **");
    end else begin
      $display("** channel_object_bringup_fsm_core: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/cobf_pkg.sv
rtl/cobf_if.sv
rtl/channel_object_bringup_fsm_core.sv
tb/cobf_bringup_checker.sv
tb/channel_object_bringup_fsm_core_tb.sv
